// ----- rtl/cmix_pkg.sv -----
// ============================================================================
// cmix_pkg: shared types and constants for the three channel color mixer
// Register indexes, fixed field widths and the pipeline control bundle.
// ============================================================================
package cmix_pkg;

  // Pipeline depth: diff, product, weight, color products, sum/saturate
  localparam int NSTAGE  = 5;
  localparam int NCHAN   = 3;

  // Fixed field widths
  localparam int SETUP_W = 48;
  localparam int COLOR_W = 24;
  localparam int MIN_W   = 16;
  localparam int SCALE_W = 32;
  localparam int COMP_W  = 8;
  localparam int IDX_W   = 3;

  typedef logic [IDX_W-1:0] reg_idx_t;

  // Configuration register indexes
  localparam reg_idx_t REG_CHAN_A_SETUP = 3'd0;
  localparam reg_idx_t REG_CHAN_B_SETUP = 3'd1;
  localparam reg_idx_t REG_CHAN_C_SETUP = 3'd2;
  localparam reg_idx_t REG_COLOR_A      = 3'd3;
  localparam reg_idx_t REG_COLOR_B      = 3'd4;
  localparam reg_idx_t REG_COLOR_C      = 3'd5;

  // Reset values
  localparam logic [SETUP_W-1:0] SETUP_RST   = 48'd65536;
  localparam logic [COLOR_W-1:0] COLOR_A_RST = 24'h0000FF;
  localparam logic [COLOR_W-1:0] COLOR_B_RST = 24'h00FF00;
  localparam logic [COLOR_W-1:0] COLOR_C_RST = 24'hFF0000;

  // Per-stage control: advance enables, valid bits, no-data tags
  typedef struct packed {
    logic [NSTAGE-1:0] adv;
    logic [NSTAGE-1:0] valid;
    logic [NSTAGE-1:0] nodata;
  } stage_ctrl_t;

endpackage

// ----- rtl/cmix_if.sv -----
// ============================================================================
// cmix_if: channel interfaces of the color mixer
// Pixel input, color result output and configuration write channels.
// ============================================================================
interface pixel_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_a;
  logic [SAMPLE_WIDTH-1:0] sample_b;
  logic [SAMPLE_WIDTH-1:0] sample_c;
  logic                    void_a;
  logic                    void_b;
  logic                    void_c;

  modport source (output valid, sample_a, sample_b, sample_c, void_a, void_b, void_c,
                  input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c, void_a, void_b, void_c,
                  output ready);
endinterface

interface pixel_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       pixel_void;

  modport source (output valid, red, green, blue, pixel_void, input ready);
  modport sink   (input valid, red, green, blue, pixel_void, output ready);
endinterface

interface cfg_if;
  logic              valid;
  logic              ready;
  cmix_pkg::reg_idx_t index;
  logic [47:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/cmix_ctrl.sv -----
// ============================================================================
// cmix_ctrl: pipeline valid and stall control
// Moves valid bits and no-data tags through the stages, with per-stage enables.
// ============================================================================
module cmix_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_nodata,
  input  logic                  out_ready,
  output logic                  in_ready,
  output cmix_pkg::stage_ctrl_t ctrl
);

  logic [cmix_pkg::NSTAGE-1:0] valid;
  logic [cmix_pkg::NSTAGE-1:0] nodata;
  logic [cmix_pkg::NSTAGE-1:0] adv;

  // A stage advances when it is empty or the next one advances
  always_comb begin
    adv[cmix_pkg::NSTAGE-1] = !valid[cmix_pkg::NSTAGE-1] || out_ready;
    for (int i = cmix_pkg::NSTAGE-2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < cmix_pkg::NSTAGE; i++) begin
        if (adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Carry the no-data tag with each transaction
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      nodata[0] <= in_nodata;
    end
    for (int i = 1; i < cmix_pkg::NSTAGE; i++) begin
      if (adv[i]) begin
        nodata[i] <= nodata[i-1];
      end
    end
  end

  assign in_ready    = adv[0];
  assign ctrl.adv    = adv;
  assign ctrl.valid  = valid;
  assign ctrl.nodata = nodata;

endmodule

// ----- rtl/cmix_weight.sv -----
// ============================================================================
// cmix_weight: normalized weight of one channel
// Stages 0 to 2: offset and pre-clamp, scale multiply, clamp to [0, 1].
// ============================================================================
module cmix_weight #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  cmix_pkg::stage_ctrl_t             ctrl,
  input  logic [SAMPLE_WIDTH-1:0]           sample,
  input  logic [cmix_pkg::SETUP_W-1:0]      setup,
  output logic [FRACTION_BITS:0]            weight
);

  localparam int DW  = ((SAMPLE_WIDTH > cmix_pkg::MIN_W) ? SAMPLE_WIDTH : cmix_pkg::MIN_W) + 1;
  localparam int CW  = (DW > FRACTION_BITS + 3) ? DW : FRACTION_BITS + 3;
  localparam int DCW = FRACTION_BITS + 2;
  localparam int PW  = DCW + cmix_pkg::SCALE_W;
  localparam int WW  = FRACTION_BITS + 1;

  logic signed [CW-1:0]          sample_ext;
  logic signed [CW-1:0]          min_ext;
  logic signed [CW-1:0]          diff;
  logic signed [CW-1:0]          one_c;
  logic [DCW-1:0]                diff_sat;
  logic [DCW-1:0]                diff_q;
  logic [cmix_pkg::SCALE_W-1:0]  scale;
  logic [PW-1:0]                 prod_c;
  logic [PW-1:0]                 prod_q;
  logic [PW-1:0]                 one_p;
  logic [WW-1:0]                 one_w;

  assign scale = setup[cmix_pkg::SCALE_W-1:0];

  // Offset the sample by the channel minimum
  assign sample_ext = {{(CW-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
  assign min_ext    = {{(CW-cmix_pkg::MIN_W){setup[cmix_pkg::SETUP_W-1]}},
                       setup[cmix_pkg::SETUP_W-1:cmix_pkg::SCALE_W]};
  assign diff       = sample_ext - min_ext;
  assign one_c      = {{(CW-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

  // Pre-clamp: any difference above one saturates for every nonzero scale
  always_comb begin
    if (diff <= 0) begin
      diff_sat = '0;
    end else if (diff > one_c) begin
      diff_sat = {1'b0, 1'b1, {(FRACTION_BITS-1){1'b0}}, 1'b1};
    end else begin
      diff_sat = diff[DCW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      diff_q <= diff_sat;
    end
  end

  // Scale multiply
  assign prod_c = {{cmix_pkg::SCALE_W{1'b0}}, diff_q} * {{DCW{1'b0}}, scale};

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      prod_q <= prod_c;
    end
  end

  // Clamp the weight at exactly one
  assign one_p = {{(PW-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
  assign one_w = {1'b1, {FRACTION_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      weight <= (prod_q > one_p) ? one_w : prod_q[WW-1:0];
    end
  end

endmodule

// ----- rtl/cmix_blend.sv -----
// ============================================================================
// cmix_blend: color mixing of three weighted channel colors
// Stage 3 forms weight times color component, stage 4 sums and saturates.
// ============================================================================
module cmix_blend #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  cmix_pkg::stage_ctrl_t         ctrl,
  input  logic [FRACTION_BITS:0]        weight_a,
  input  logic [FRACTION_BITS:0]        weight_b,
  input  logic [FRACTION_BITS:0]        weight_c,
  input  logic [cmix_pkg::COLOR_W-1:0]  color_a,
  input  logic [cmix_pkg::COLOR_W-1:0]  color_b,
  input  logic [cmix_pkg::COLOR_W-1:0]  color_c,
  output logic [cmix_pkg::COMP_W-1:0]   red,
  output logic [cmix_pkg::COMP_W-1:0]   green,
  output logic [cmix_pkg::COMP_W-1:0]   blue
);

  localparam int WW = FRACTION_BITS + 1;
  localparam int MW = WW + cmix_pkg::COMP_W;
  localparam int SW = MW + 2;
  localparam int TW = SW - FRACTION_BITS;

  logic [WW-1:0]                 weights [cmix_pkg::NCHAN];
  logic [cmix_pkg::COLOR_W-1:0]  colors  [cmix_pkg::NCHAN];
  logic [MW-1:0]                 mix     [cmix_pkg::NCHAN][3];
  logic [SW-1:0]                 sum     [3];
  logic [TW-1:0]                 whole   [3];
  logic [cmix_pkg::COMP_W-1:0]   comp    [3];

  assign weights[0] = weight_a;
  assign weights[1] = weight_b;
  assign weights[2] = weight_c;
  assign colors[0]  = color_a;
  assign colors[1]  = color_b;
  assign colors[2]  = color_c;

  // Weight each color component
  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      for (int ch = 0; ch < cmix_pkg::NCHAN; ch++) begin
        for (int k = 0; k < 3; k++) begin
          mix[ch][k] <= {{cmix_pkg::COMP_W{1'b0}}, weights[ch]}
                      * {{WW{1'b0}}, colors[ch][k*cmix_pkg::COMP_W +: cmix_pkg::COMP_W]};
        end
      end
    end
  end

  // Sum, drop the fraction, saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k]   = {2'b00, mix[0][k]} + {2'b00, mix[1][k]} + {2'b00, mix[2][k]};
      whole[k] = sum[k][SW-1:FRACTION_BITS];
      if (whole[k] > TW'(255)) begin
        comp[k] = '1;
      end else begin
        comp[k] = whole[k][cmix_pkg::COMP_W-1:0];
      end
    end
  end

  // Drop color on no-data pixels
  always_ff @(posedge clk) begin
    if (ctrl.adv[4]) begin
      if (ctrl.nodata[3]) begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end else begin
        red   <= comp[0];
        green <= comp[1];
        blue  <= comp[2];
      end
    end
  end

endmodule

// ----- rtl/three_channel_color_mixer_unit.sv -----
// ============================================================================
// three_channel_color_mixer_unit: three band color composite
// Normalizes three samples and mixes three configurable colors into RGB.
// ============================================================================
// Usage:
//   pixel  : input transactions of three signed samples plus no-data flags.
//   result : output transactions of red, green, blue and pixel_void.
//   cfg    : register writes (index 0..5: three channel setups, three colors);
//            always ready, write only while no pixel is in flight.
// Throughput is one pixel per clock while result.ready stays high. The five
// register stages are offset/pre-clamp, scale multiply, weight clamp, color
// multiply and sum/saturate.
// Reset clears all stage valid bits and loads the register defaults
// (min 0, scale 1.0, colors red, green, blue for channels A, B, C).
// When the receiver stalls, the output register holds its transaction and
// the stages behind it fill up; pixel.ready drops only once every stage
// holds a transaction, so nothing is lost or repeated.
// ============================================================================
module three_channel_color_mixer_unit #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  pixel_in_if.sink     pixel,
  pixel_out_if.source  result,
  cfg_if.sink          cfg
);

  logic [cmix_pkg::SETUP_W-1:0] setup_a;
  logic [cmix_pkg::SETUP_W-1:0] setup_b;
  logic [cmix_pkg::SETUP_W-1:0] setup_c;
  logic [cmix_pkg::COLOR_W-1:0] color_a;
  logic [cmix_pkg::COLOR_W-1:0] color_b;
  logic [cmix_pkg::COLOR_W-1:0] color_c;
  logic [FRACTION_BITS:0]       weight_a;
  logic [FRACTION_BITS:0]       weight_b;
  logic [FRACTION_BITS:0]       weight_c;
  cmix_pkg::stage_ctrl_t        ctrl;
  logic                         in_nodata;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_a <= cmix_pkg::SETUP_RST;
      setup_b <= cmix_pkg::SETUP_RST;
      setup_c <= cmix_pkg::SETUP_RST;
      color_a <= cmix_pkg::COLOR_A_RST;
      color_b <= cmix_pkg::COLOR_B_RST;
      color_c <= cmix_pkg::COLOR_C_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        cmix_pkg::REG_CHAN_A_SETUP: setup_a <= cfg.data;
        cmix_pkg::REG_CHAN_B_SETUP: setup_b <= cfg.data;
        cmix_pkg::REG_CHAN_C_SETUP: setup_c <= cfg.data;
        cmix_pkg::REG_COLOR_A:      color_a <= cfg.data[cmix_pkg::COLOR_W-1:0];
        cmix_pkg::REG_COLOR_B:      color_b <= cfg.data[cmix_pkg::COLOR_W-1:0];
        cmix_pkg::REG_COLOR_C:      color_c <= cfg.data[cmix_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign in_nodata = pixel.void_a | pixel.void_b | pixel.void_c;

  cmix_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_nodata (in_nodata),
    .out_ready (result.ready),
    .in_ready  (pixel.ready),
    .ctrl      (ctrl)
  );

  // Per-channel weights
  cmix_weight #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_weight_a (
    .clk (clk), .ctrl (ctrl), .sample (pixel.sample_a), .setup (setup_a), .weight (weight_a)
  );

  cmix_weight #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_weight_b (
    .clk (clk), .ctrl (ctrl), .sample (pixel.sample_b), .setup (setup_b), .weight (weight_b)
  );

  cmix_weight #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_weight_c (
    .clk (clk), .ctrl (ctrl), .sample (pixel.sample_c), .setup (setup_c), .weight (weight_c)
  );

  // Color mix and output register
  cmix_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend (
    .clk      (clk),
    .ctrl     (ctrl),
    .weight_a (weight_a),
    .weight_b (weight_b),
    .weight_c (weight_c),
    .color_a  (color_a),
    .color_b  (color_b),
    .color_c  (color_c),
    .red      (result.red),
    .green    (result.green),
    .blue     (result.blue)
  );

  assign result.valid      = ctrl.valid[cmix_pkg::NSTAGE-1];
  assign result.pixel_void = ctrl.nodata[cmix_pkg::NSTAGE-1];

endmodule

// ----- rtl/cmix_checker.sv -----
// ============================================================================
// cmix_checker: port-level assertions for the color mixer
// Checks reset, stall hold, no-data output and fixed latency at full rate.
// ============================================================================
module cmix_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_void,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_void,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_void) && $stable(red)
                                   && $stable(green) && $stable(blue)))
    else $error("stalled result changed");

  // No-data results carry no color
  a_void_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_void) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("no-data result with nonzero color");

  // With the receiver ready throughout, an accepted no-data pixel reaches the output as a no-data result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($past(in_valid && in_ready && in_void, 5) && !$past(rst, 5)
     && $past(out_ready, 1) && $past(out_ready, 2)
     && $past(out_ready, 3) && $past(out_ready, 4)
     && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4))
    |-> (out_valid && out_void))
    else $error("no-data pixel not delivered after five cycles");

endmodule

bind three_channel_color_mixer_unit cmix_checker u_cmix_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .in_void   (pixel.void_a | pixel.void_b | pixel.void_c),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_void  (result.pixel_void),
  .red       (result.red),
  .green     (result.green),
  .blue      (result.blue)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for three_channel_color_mixer_unit
// Drives pixel transactions and register writes, predicts every RGB result
// from the current register set, and compares results field by field in
// order. Random backpressure and source gaps cover the pipeline's stall paths.
// ============================================================================
module tb_top;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC       = 16;
  localparam int NUM_IDX    = 1 << cmix_pkg::IDX_W;
  localparam int MAX_SHOWN  = 10;
  localparam int DRAIN_MAX  = 4000;
  localparam int WEIGHT_ONE = 1 << FRAC;

  // Indexes past the last register; writes there must change nothing
  localparam cmix_pkg::reg_idx_t REG_SPARE_LO = 3'd6;
  localparam cmix_pkg::reg_idx_t REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic                void_a;
    logic                void_b;
    logic                void_c;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pixel_void;
  } rgb_t;

  // Register shadow, mixing predictor and queue of expected RGB results
  class rgb_ledger;
    logic [cmix_pkg::SETUP_W-1:0] setup [cmix_pkg::NCHAN];
    logic [cmix_pkg::COLOR_W-1:0] color [cmix_pkg::NCHAN];
    rgb_t                         pending_rgb [$];
    int unsigned                  errors;

    function new();
      setup[0] = cmix_pkg::SETUP_RST;
      setup[1] = cmix_pkg::SETUP_RST;
      setup[2] = cmix_pkg::SETUP_RST;
      color[0] = cmix_pkg::COLOR_A_RST;
      color[1] = cmix_pkg::COLOR_B_RST;
      color[2] = cmix_pkg::COLOR_C_RST;
      errors   = 0;
    endfunction

    function void write_reg(cmix_pkg::reg_idx_t idx, logic [cmix_pkg::SETUP_W-1:0] data);
      case (idx)
        cmix_pkg::REG_CHAN_A_SETUP, cmix_pkg::REG_CHAN_B_SETUP,
        cmix_pkg::REG_CHAN_C_SETUP: setup[idx] = data;
        cmix_pkg::REG_COLOR_A, cmix_pkg::REG_COLOR_B, cmix_pkg::REG_COLOR_C:
          color[idx - cmix_pkg::REG_COLOR_A] = data[cmix_pkg::COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Normalized weight in 0..1.0 with FRAC fraction bits
    function automatic logic [FRAC:0] chan_weight(logic signed [SAMPLE_W-1:0] smp,
                                                  logic [cmix_pkg::SETUP_W-1:0] stp);
      longint          lo;
      longint          diff;
      longint unsigned prod;
      lo   = $signed(stp[cmix_pkg::SETUP_W-1:cmix_pkg::SCALE_W]);
      diff = longint'(smp) - lo;
      if (diff <= 0 || stp[cmix_pkg::SCALE_W-1:0] == '0) return '0;
      prod = diff;
      prod = prod * stp[cmix_pkg::SCALE_W-1:0];
      if (prod > WEIGHT_ONE) return (FRAC+1)'(WEIGHT_ONE);
      return prod[FRAC:0];
    endfunction

    function automatic rgb_t mix_pixel(pixel_t px);
      rgb_t            o;
      logic [FRAC:0]   w [cmix_pkg::NCHAN];
      longint unsigned acc;
      logic [7:0]      comp [3];
      o = '0;
      if (px.void_a | px.void_b | px.void_c) begin
        o.pixel_void = 1'b1;
        return o;
      end
      w[0] = chan_weight(px.sample_a, setup[0]);
      w[1] = chan_weight(px.sample_b, setup[1]);
      w[2] = chan_weight(px.sample_c, setup[2]);
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        for (int ch = 0; ch < cmix_pkg::NCHAN; ch++)
          acc += w[ch] * color[ch][cmix_pkg::COMP_W*k +: cmix_pkg::COMP_W];
        acc = acc >> FRAC;
        comp[k] = (acc > 255) ? 8'd255 : acc[7:0];
      end
      o.red   = comp[0];
      o.green = comp[1];
      o.blue  = comp[2];
      return o;
    endfunction

    function void note_pixel(pixel_t px);
      pending_rgb.push_back(mix_pixel(px));
    endfunction

    function void check_rgb(rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected result: r=%0d g=%0d b=%0d void=%0b",
                   got.red, got.green, got.blue, got.pixel_void);
        return;
      end
      want = pending_rgb.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.pixel_void !== want.pixel_void) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("rgb mismatch at %0t: expected r=%0d g=%0d b=%0d void=%0b,",
                   $realtime, want.red, want.green, want.blue, want.pixel_void,
                   " got r=%0d g=%0d b=%0d void=%0b",
                   got.red, got.green, got.blue, got.pixel_void);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   src_gaps;
  bit   sink_gaps;

  logic [cmix_pkg::SETUP_W-1:0] reg_vals [NUM_IDX];
  rgb_ledger                    ledger = new();

  pixel_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) pix_if ();
  pixel_out_if                           res_if ();
  cfg_if                                 cfg_bus ();

  three_channel_color_mixer_unit #(
    .SAMPLE_WIDTH (SAMPLE_W),
    .FRACTION_BITS(FRAC)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix_if),
    .result(res_if),
    .cfg   (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Toggle result backpressure in bursts; hold ready high when gaps are off
  always begin
    if (sink_gaps && $urandom_range(0, 2) == 0) begin
      res_if.ready <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    res_if.ready <= 1'b1;
    repeat ($urandom_range(1, 20)) @(posedge clk);
  end

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      ledger.check_rgb('{red: res_if.red, green: res_if.green, blue: res_if.blue,
                         pixel_void: res_if.pixel_void});
  end

  function automatic pixel_t mk_px(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                   logic [SAMPLE_W-1:0] c, logic [2:0] voids);
    pixel_t px;
    px.sample_a = a;
    px.sample_b = b;
    px.sample_c = c;
    {px.void_a, px.void_b, px.void_c} = voids;
    return px;
  endfunction

  // Mostly full-range samples, some just around each channel's offset
  function automatic pixel_t rand_pixel();
    logic [SAMPLE_W-1:0] smp [cmix_pkg::NCHAN];
    for (int ch = 0; ch < cmix_pkg::NCHAN; ch++) begin
      if ($urandom_range(0, 2) == 0)
        smp[ch] = SAMPLE_W'(ledger.setup[ch][cmix_pkg::SETUP_W-1:cmix_pkg::SCALE_W]
                            + $urandom_range(0, 40) - 8);
      else
        smp[ch] = SAMPLE_W'($urandom);
    end
    return mk_px(smp[0], smp[1], smp[2],
                 {$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                  $urandom_range(0, 9) == 0});
  endfunction

  function automatic logic [cmix_pkg::SETUP_W-1:0] rand_setup();
    logic [cmix_pkg::MIN_W-1:0]   lo;
    logic [cmix_pkg::SCALE_W-1:0] sc;
    case ($urandom_range(0, 5))
      0:       lo = 16'h8000;
      1:       lo = 16'h7FFF;
      default: lo = cmix_pkg::MIN_W'($urandom);
    endcase
    case ($urandom_range(0, 6))
      0:       sc = '0;
      1:       sc = '1;
      2:       sc = cmix_pkg::SCALE_W'(WEIGHT_ONE);
      3:       sc = $urandom;
      default: sc = $urandom_range(0, 1 << $urandom_range(0, 20));
    endcase
    return {lo, sc};
  endfunction

  function automatic logic [cmix_pkg::SETUP_W-1:0] rand_color();
    logic [cmix_pkg::COLOR_W-1:0] col;
    case ($urandom_range(0, 5))
      0:       col = '0;
      1:       col = '1;
      default: col = cmix_pkg::COLOR_W'($urandom);
    endcase
    // junk above the color field must be dropped
    return {cmix_pkg::COLOR_W'($urandom), col};
  endfunction

  // Write the masked registers from reg_vals, back to back
  task automatic load_regs(input logic [NUM_IDX-1:0] mask);
    for (int i = 0; i < NUM_IDX; i++) begin
      if (mask[i]) begin
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= cmix_pkg::reg_idx_t'(i);
        cfg_bus.data  <= reg_vals[i];
        do @(posedge clk); while (!cfg_bus.ready);
        ledger.write_reg(cmix_pkg::reg_idx_t'(i), reg_vals[i]);
      end
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_t px);
    pix_if.valid    <= 1'b1;
    pix_if.sample_a <= px.sample_a;
    pix_if.sample_b <= px.sample_b;
    pix_if.sample_c <= px.sample_c;
    pix_if.void_a   <= px.void_a;
    pix_if.void_b   <= px.void_b;
    pix_if.void_c   <= px.void_c;
    do @(posedge clk); while (!pix_if.ready);
    ledger.note_pixel(px);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for all predicted results, bounded
  task automatic drain(input int unsigned settle);
    int unsigned waited;
    waited = 0;
    pix_if.valid <= 1'b0;
    while (ledger.pending_rgb.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    #400000;
    $display("three_channel_color_mixer_unit regression: fail");
    $finish;
  end

  initial begin
    src_gaps         = 1'b1;
    sink_gaps        = 1'b1;
    rst             <= 1'b1;
    pix_if.valid    <= 1'b0;
    pix_if.sample_a <= '0;
    pix_if.sample_b <= '0;
    pix_if.sample_c <= '0;
    pix_if.void_a   <= 1'b0;
    pix_if.void_b   <= 1'b0;
    pix_if.void_c   <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= cmix_pkg::REG_CHAN_A_SETUP;
    cfg_bus.data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: binary weights, pure red/green/blue, no-data flags
    send_pixel(mk_px(16'h0000, 16'h0000, 16'h0000, 3'b000));
    send_pixel(mk_px(16'h0001, 16'h0001, 16'h0001, 3'b000));
    send_pixel(mk_px(16'h7FFF, 16'h8000, 16'h0000, 3'b000));
    send_pixel(mk_px(16'h8000, 16'h7FFF, 16'hFFFF, 3'b000));
    send_pixel(mk_px(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b100));
    send_pixel(mk_px(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b010));
    send_pixel(mk_px(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b001));
    send_pixel(mk_px(16'h8000, 16'h7FFF, 16'hFFFF, 3'b111));
    drain(2);

    // Lowest offset, smallest scale: fractional weights; poke spare indexes
    reg_vals[cmix_pkg::REG_CHAN_A_SETUP] = {16'h8000, 32'h0000_0001};
    reg_vals[cmix_pkg::REG_CHAN_B_SETUP] = {16'h8000, 32'h0000_0001};
    reg_vals[cmix_pkg::REG_CHAN_C_SETUP] = {16'h8000, 32'h0000_0001};
    reg_vals[cmix_pkg::REG_COLOR_A]      = {24'hFFFFFF, 24'hFFFFFF};
    reg_vals[cmix_pkg::REG_COLOR_B]      = {24'h0, 24'h808080};
    reg_vals[cmix_pkg::REG_COLOR_C]      = {24'h0, 24'h030201};
    reg_vals[REG_SPARE_LO]               = '1;
    reg_vals[REG_SPARE_HI]               = '0;
    load_regs('1);
    send_pixel(mk_px(16'h8000, 16'h8000, 16'h8000, 3'b000));
    send_pixel(mk_px(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b000));
    send_pixel(mk_px(16'h0000, 16'h4000, 16'hC000, 3'b000));
    send_pixel(mk_px(16'h8001, 16'h7FFE, 16'h0001, 3'b000));
    drain(2);

    // Highest offset and largest scale: nothing ever reaches above the offset
    reg_vals[cmix_pkg::REG_CHAN_A_SETUP] = {16'h7FFF, 32'hFFFF_FFFF};
    reg_vals[cmix_pkg::REG_CHAN_B_SETUP] = {16'h7FFF, 32'hFFFF_FFFF};
    reg_vals[cmix_pkg::REG_CHAN_C_SETUP] = {16'h7FFF, 32'hFFFF_FFFF};
    load_regs(8'b0000_0111);
    send_pixel(mk_px(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b000));
    send_pixel(mk_px(16'h8000, 16'h0000, 16'h7FFE, 3'b000));
    drain(2);

    // Zero scale, saturated weight, half steps; white everywhere to clip sums
    reg_vals[cmix_pkg::REG_CHAN_A_SETUP] = {16'h8000, 32'h0000_0000};
    reg_vals[cmix_pkg::REG_CHAN_B_SETUP] = {16'h8000, 32'hFFFF_FFFF};
    reg_vals[cmix_pkg::REG_CHAN_C_SETUP] = {16'h0064, 32'h0000_8000};
    reg_vals[cmix_pkg::REG_COLOR_A]      = {24'h0, 24'hFFFFFF};
    reg_vals[cmix_pkg::REG_COLOR_B]      = {24'h0, 24'hFFFFFF};
    reg_vals[cmix_pkg::REG_COLOR_C]      = {24'h0, 24'hFFFFFF};
    load_regs(8'b0011_1111);
    send_pixel(mk_px(16'h7FFF, 16'h8000, 16'h0065, 3'b000));
    send_pixel(mk_px(16'h7FFF, 16'h8001, 16'h0066, 3'b000));
    send_pixel(mk_px(16'h0000, 16'h8000, 16'h0065, 3'b000));
    send_pixel(mk_px(16'h0000, 16'h0000, 16'h0064, 3'b000));
    drain(2);

    // Random phases; the first rewrites every register, each later one a random subset
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < NUM_IDX; i++)
        reg_vals[i] = (i < cmix_pkg::REG_COLOR_A) ? rand_setup() : rand_color();
      src_gaps  = (ph != 7) && ($urandom_range(0, 3) != 0);
      sink_gaps = (ph != 7) && ($urandom_range(0, 3) != 0);
      load_regs((ph == 0) ? '1 : NUM_IDX'($urandom));
      repeat (50) send_pixel(rand_pixel());
      drain(2);
    end

    drain(cmix_pkg::NSTAGE + 4);
    if (ledger.pending_rgb.size() != 0) begin
      ledger.errors++;
      $display("%0d expected results never arrived", ledger.pending_rgb.size());
    end
    if (ledger.errors == 0)
      $display("three_channel_color_mixer_unit regression: pass");
    else
      $display("three_channel_color_mixer_unit regression: fail");
    $finish;
  end

endmodule
